// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define B91_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define B91_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define B91_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/b91enc_pkg.sv -----
// Package with types, constants, divide-by-91 and alphabet lookup for the base91 encoder.
package b91enc_pkg;

    localparam int FIFO_DEPTH  = 2;
    localparam int QUEUE_W     = 13;
    localparam int VALUE_W     = 14;
    localparam int QUOT_W      = 8;
    localparam int RECIP_91    = 11523;   // ceil(2^20 / 91), exact for 14-bit values
    localparam int RECIP_SHIFT = 20;
    localparam int PROD_W      = 28;

    // One accepted byte that yields at least one character
    typedef struct packed {
        logic                 pair;     // byte completed a 13/14-bit value
        logic [VALUE_W-1:0]   pv;       // value of the pair
        logic [QUOT_W-1:0]    pq;       // pv div 91
        logic [QUEUE_W-1:0]   fv;       // remaining bits for the flush
        logic [QUOT_W-1:0]    fq;       // fv div 91
        logic [2:0]           n_chars;  // characters to emit, 1 to 4
        logic                 last;     // mark the final character
    } t_entry;

    function automatic logic [QUOT_W-1:0] div91(input logic [VALUE_W-1:0] v);
        logic [PROD_W-1:0] p;
        p = PROD_W'(v) * PROD_W'(RECIP_91);
        return QUOT_W'(p >> RECIP_SHIFT);
    endfunction

    function automatic logic [7:0] alpha(input logic [7:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        priority if (idx < 8'd26) begin
            ch = idx + 8'h41;
        end else if (idx < 8'd52) begin
            ch = idx - 8'd26 + 8'h61;
        end else if (idx < 8'd62) begin
            ch = idx - 8'd52 + 8'h30;
        end else begin
            // punctuation block, three symbols differ from the published set
            unique case (idx)
                8'd62:   ch = 8'h21;
                8'd63:   ch = 8'h23;
                8'd64:   ch = 8'h24;
                8'd65:   ch = 8'h25;
                8'd66:   ch = 8'h26;
                8'd67:   ch = 8'h28;
                8'd68:   ch = 8'h29;
                8'd69:   ch = 8'h2A;
                8'd70:   ch = 8'h2B;
                8'd71:   ch = 8'h2C;
                8'd72:   ch = 8'h2E;
                8'd73:   ch = 8'h2F;
                8'd74:   ch = 8'h3A;
                8'd75:   ch = 8'h3B;
                8'd76:   ch = 8'h2D;
                8'd77:   ch = 8'h3D;
                8'd78:   ch = 8'h5C;
                8'd79:   ch = 8'h3F;
                8'd80:   ch = 8'h40;
                8'd81:   ch = 8'h5B;
                8'd82:   ch = 8'h5D;
                8'd83:   ch = 8'h5E;
                8'd84:   ch = 8'h5F;
                8'd85:   ch = 8'h60;
                8'd86:   ch = 8'h7B;
                8'd87:   ch = 8'h7C;
                8'd88:   ch = 8'h7D;
                8'd89:   ch = 8'h7E;
                8'd90:   ch = 8'h27;
                default: ch = 8'h00;
            endcase
        end
        return ch;
    endfunction

endpackage

// ----- rtl/core/b91enc_front.sv -----
// Front end: accept bytes, update the bit queue, queue up character work.
module b91enc_front
    import b91enc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic [7:0]   i_data,
    input  logic         i_last,
    input  logic         i_full,
    output logic         o_ready,
    output logic         o_push,
    output t_entry       o_entry
);

    logic [QUEUE_W-1:0] r_queue, n_queue;
    logic [3:0]         r_cnt, n_cnt;

    logic               accept;
    logic [20:0]        wide;
    logic [4:0]         wcnt;
    logic               has_pair;
    logic               take13;
    logic [QUEUE_W-1:0] rest;
    logic [4:0]         rcnt;
    logic [VALUE_W-1:0] pv;
    logic [1:0]         fn;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        wide     = {8'b0, r_queue} | (21'({13'b0, i_data}) << r_cnt);
        wcnt     = {1'b0, r_cnt} + 5'd8;
        has_pair = wcnt > 5'd13;
        take13   = wide[12:0] > 13'd88;
        pv       = take13 ? {1'b0, wide[12:0]} : wide[13:0];
        if (has_pair) begin
            rest = take13 ? {5'b0, wide[20:13]} : {6'b0, wide[20:14]};
            rcnt = take13 ? wcnt - 5'd13 : wcnt - 5'd14;
        end else begin
            rest = wide[12:0];
            rcnt = wcnt;
        end
        fn = 2'd0;
        if (i_last && rcnt != 5'd0) begin
            fn = (rcnt > 5'd7 || rest > 13'd90) ? 2'd2 : 2'd1;
        end
    end

    always_comb begin
        o_entry.pair    = has_pair;
        o_entry.pv      = pv;
        o_entry.pq      = div91(pv);
        o_entry.fv      = rest;
        o_entry.fq      = div91({1'b0, rest});
        o_entry.n_chars = (has_pair ? 3'd2 : 3'd0) + {1'b0, fn};
        o_entry.last    = i_last;
        o_push          = accept && (o_entry.n_chars != 3'd0);
    end

    always_comb begin
        n_queue = r_queue;
        n_cnt   = r_cnt;
        if (accept) begin
            // clear on the final byte
            n_queue = i_last ? '0 : rest;
            n_cnt   = i_last ? 4'd0 : rcnt[3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queue <= '0;
            r_cnt   <= 4'd0;
        end else begin
            r_queue <= n_queue;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ----- rtl/core/b91enc_fifo.sv -----
// Short queue of pending character work between front and back.
module b91enc_fifo
    import b91enc_pkg::*;
#(
    parameter int Depth = FIFO_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_entry  i_entry,
    input  logic    i_pop,
    output t_entry  o_head,
    output logic    o_full,
    output logic    o_empty
);

    localparam int PtrW = $clog2(Depth);
    localparam int CntW = $clog2(Depth + 1);

    t_entry             r_mem [Depth];
    logic [PtrW-1:0]    r_wr, n_wr;
    logic [PtrW-1:0]    r_rd, n_rd;
    logic [CntW-1:0]    r_cnt, n_cnt;

    assign o_full  = r_cnt == CntW'(Depth);
    assign o_empty = r_cnt == '0;
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PtrW'(Depth - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PtrW'(Depth - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ----- rtl/core/b91enc_back.sv -----
// Back end: turn queued values into characters, one character per cycle while the output is not stalled.
module b91enc_back
    import b91enc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_entry       i_head,
    input  logic         i_empty,
    input  logic         i_ready,
    output logic         o_pop,
    output logic         o_valid,
    output logic [7:0]   o_char,
    output logic         o_final
);

    logic [1:0]         r_idx, n_idx;
    logic               r_valid, n_valid;
    logic [7:0]         r_char, n_char;
    logic               r_final, n_final;

    logic               advance;
    logic               at_end;
    logic               src_flush;
    logic [VALUE_W-1:0] v;
    logic [QUOT_W-1:0]  q;
    logic [VALUE_W:0]   q91;
    logic [6:0]         rem;
    logic [7:0]         sel;

    assign advance = !i_empty && (!r_valid || i_ready);
    assign at_end  = {1'b0, r_idx} == i_head.n_chars - 3'd1;
    assign o_pop   = advance && at_end;

    always_comb begin
        // even positions take the remainder, odd ones the quotient
        src_flush = !i_head.pair || r_idx[1];
        v         = src_flush ? {1'b0, i_head.fv} : i_head.pv;
        q         = src_flush ? i_head.fq : i_head.pq;
        // q * 91 as q * 128 - q * 32 - q * 4 - q
        q91       = {q, 7'b0} - {2'b0, q, 5'b0} - {5'b0, q, 2'b0} - {7'b0, q};
        rem       = 7'(v - q91[VALUE_W-1:0]);
        sel       = r_idx[0] ? q : {1'b0, rem};
    end

    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid && !i_ready;
        n_char  = r_char;
        n_final = r_final;
        if (advance) begin
            n_idx   = at_end ? 2'd0 : r_idx + 2'd1;
            n_valid = 1'b1;
            n_char  = alpha(sel);
            n_final = i_head.last && at_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char  <= n_char;
        r_final <= n_final;
    end

    assign o_valid = r_valid;
    assign o_char  = r_char;
    assign o_final = r_final;

endmodule

// ----- rtl/core/base91_text_encoder.sv -----
// Top level of the streaming base91 text encoder.
//
//   channel   direction  tdata             tlast
//   s         in         data_byte [7:0]   end_of_message
//   m         out        code_char [7:0]   final_char
//
// Each byte yields 0 to 4 characters; the back end emits one per cycle while the
// output is not stalled. The first character of a byte is registered in the work
// queue and then in the output register before it is valid.
// Reset is synchronous and clears the bit queue, the work queue and the output valid flag.
// A stalled output only holds the back end; the front keeps taking bytes until
// the work queue of FifoDepth entries fills.
`include "assert_macros.svh"

module base91_text_encoder
    import b91enc_pkg::*;
#(
    parameter int FifoDepth = FIFO_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] code_char
    output logic        o_m_tlast
);

    t_entry push_entry;
    t_entry head;
    logic   push;
    logic   pop;
    logic   full;
    logic   empty;

    b91enc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_data  (i_s_tdata),
        .i_last  (i_s_tlast),
        .i_full  (full),
        .o_ready (o_s_tready),
        .o_push  (push),
        .o_entry (push_entry)
    );

    b91enc_fifo #(
        .Depth (FifoDepth)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (full),
        .o_empty (empty)
    );

    b91enc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (empty),
        .i_ready (i_m_tready),
        .o_pop   (pop),
        .o_valid (o_m_tvalid),
        .o_char  (o_m_tdata),
        .o_final (o_m_tlast)
    );

    `B91_ASSERT_IMP(a_push_not_full, push, !full, "word pushed into a full work queue")
    `B91_ASSERT_IMP(a_pop_not_empty, pop, !empty, "word popped from an empty work queue")
    `B91_ASSERT_IMP(a_char_printable, o_m_tvalid,
        o_m_tdata >= 8'd33 && o_m_tdata <= 8'd126, "character outside the alphabet")
    `B91_ASSERT_IMP(a_entry_size, !empty,
        head.n_chars != 3'd0 && head.n_chars <= 3'd4, "queued word with bad length")

endmodule
